>>> rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and helpers for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned ChainWords = 5;
  localparam int unsigned ChainAw    = 3;
  localparam int unsigned Rounds     = 80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  POS_LAST     = 6'd63;
  localparam logic [5:0]  POS_PRE_LEN  = 6'd55;
  localparam logic [2:0]  CI_LAST      = 3'd5;
  localparam logic [2:0]  WORD_LAST    = 3'd4;
  localparam logic [6:0]  ROUND_LAST   = 7'd79;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  // word 15 is the oldest (front of the schedule window)
  typedef logic [15:0][31:0] sched_t;

  function automatic logic [31:0] chain_iv(input logic [ChainAw-1:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h67452301;
      3'd1: v = 32'hEFCDAB89;
      3'd2: v = 32'h98BADCFE;
      3'd3: v = 32'h10325476;
      3'd4: v = 32'hC3D2E1F0;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

>>> rtl/sha1md_round.sv
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round: working-word update and next message schedule word.
// ----------------------------------------------------------------------------
module sha1md_round (
  input  sha1md_pkg::work_t  work_i,
  input  logic [6:0]         round_i,
  input  sha1md_pkg::sched_t sched_i,
  output sha1md_pkg::work_t  work_o,
  output logic [31:0]        sched_new_o
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round_i < 7'd20) begin
      f = work_i.d ^ (work_i.b & (work_i.c ^ work_i.d));
      k = sha1md_pkg::K0;
    end else if (round_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1md_pkg::K1;
    end else if (round_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.d & (work_i.b | work_i.c));
      k = sha1md_pkg::K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1md_pkg::K3;
    end
  end

  always_comb begin
    work_o.a = sha1md_pkg::rotl(work_i.a, 5) + f + work_i.e + k + sched_i[15];
    work_o.b = work_i.a;
    work_o.c = sha1md_pkg::rotl(work_i.b, 30);
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

  // w[r+16] = rotl1(w[r+13] ^ w[r+8] ^ w[r+2] ^ w[r])
  assign sched_new_o = sha1md_pkg::rotl(sched_i[2] ^ sched_i[7] ^ sched_i[13] ^ sched_i[15], 1);

endmodule

>>> rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// Byte-serial SHA-1: packs bytes into the block window, compresses each full
// block, pads the message and streams out the five digest words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while filling, stalled while a block is in work;
//   each 64-byte block then passes through chain read, the rounds and write-back.
// Message end: padding shifts in one byte per cycle (up to 64), then the
//   length, then one or two compressions, then a read and a load per digest word.
// The chain words live in a 5-entry RAM with a registered read port.
// Reset: asynchronous, active low; chain valid bits clear so unwritten
//   entries read as the SHA-1 initial values. The same clear follows each digest.
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_number
  output logic        m_axis_tlast    // digest_done
);

  sha1md_pkg::state_e state_q, state_d;

  logic [5:0]  pos_q, pos_d;
  logic [60:0] msg_q, msg_d;
  logic        fin_q, fin_d;
  logic        mark_q, mark_d;
  logic        last_q, last_d;
  logic [2:0]  ci_q, ci_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  wi_q, wi_d;
  logic [4:0]  cvalid_q, cvalid_d;
  logic        m_valid_q, m_valid_d;

  sha1md_pkg::sched_t blk_q, blk_d;
  sha1md_pkg::work_t  work_q, work_d, work_rnd;
  logic [31:0]        sched_new;
  logic [31:0]        m_data_q, m_data_d;
  logic [2:0]         m_num_q, m_num_d;

  logic [31:0] chain_mem [sha1md_pkg::ChainWords];
  logic [31:0] mem_rd_q;
  logic [2:0]  rd_idx_q;
  logic        mem_re;
  logic [2:0]  mem_ra;
  logic        mem_we;
  logic [31:0] mem_wd;
  logic [31:0] rd_eff;

  logic        s_acc;
  logic        m_acc;
  logic        byte_en;
  logic [7:0]  byte_v;

  assign s_axis_tready = (state_q == sha1md_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign m_acc         = m_valid_q & m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_num_q;
  assign m_axis_tlast  = (m_num_q == sha1md_pkg::WORD_LAST);

  assign rd_eff = cvalid_q[rd_idx_q] ? mem_rd_q : sha1md_pkg::chain_iv(rd_idx_q);

  sha1md_round u_round (
    .work_i      (work_q),
    .round_i     (rnd_q),
    .sched_i     (blk_q),
    .work_o      (work_rnd),
    .sched_new_o (sched_new)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (pos_q == sha1md_pkg::POS_LAST) begin
            state_d = sha1md_pkg::ST_LOAD;
          end else if (s_axis_tlast) begin
            state_d = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_LOAD: begin
        if (ci_q == sha1md_pkg::CI_LAST) state_d = sha1md_pkg::ST_ROUND;
      end
      sha1md_pkg::ST_ROUND: begin
        if (rnd_q == sha1md_pkg::ROUND_LAST) state_d = sha1md_pkg::ST_ADD;
      end
      sha1md_pkg::ST_ADD: begin
        if (ci_q == sha1md_pkg::CI_LAST) begin
          if (last_q) begin
            state_d = sha1md_pkg::ST_OUT_RD;
          end else if (fin_q) begin
            state_d = sha1md_pkg::ST_PAD;
          end else begin
            state_d = sha1md_pkg::ST_IDLE;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (pos_q == sha1md_pkg::POS_PRE_LEN) begin
          state_d = sha1md_pkg::ST_LEN;
        end else if (pos_q == sha1md_pkg::POS_LAST) begin
          state_d = sha1md_pkg::ST_LOAD;
        end
      end
      sha1md_pkg::ST_LEN: begin
        state_d = sha1md_pkg::ST_LOAD;
      end
      sha1md_pkg::ST_OUT_RD: begin
        if (!m_valid_q || m_acc) state_d = sha1md_pkg::ST_OUT_LD;
      end
      sha1md_pkg::ST_OUT_LD: begin
        if (wi_q == sha1md_pkg::WORD_LAST) begin
          state_d = sha1md_pkg::ST_IDLE;
        end else begin
          state_d = sha1md_pkg::ST_OUT_RD;
        end
      end
      default: state_d = sha1md_pkg::ST_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    pos_d     = pos_q;
    msg_d     = msg_q;
    fin_d     = fin_q;
    mark_d    = mark_q;
    last_d    = last_q;
    ci_d      = ci_q;
    rnd_d     = rnd_q;
    wi_d      = wi_q;
    cvalid_d  = cvalid_q;
    m_valid_d = m_valid_q & ~m_acc;
    blk_d     = blk_q;
    work_d    = work_q;
    m_data_d  = m_data_q;
    m_num_d   = m_num_q;
    mem_re    = 1'b0;
    mem_ra    = ci_q;
    mem_we    = 1'b0;
    mem_wd    = rd_eff + work_q.a;
    byte_en   = 1'b0;
    byte_v    = s_axis_tdata;

    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (s_acc) begin
          byte_en = 1'b1;
          msg_d   = msg_q + 61'd1;
          if (s_axis_tlast) fin_d = 1'b1;
        end
      end
      sha1md_pkg::ST_LOAD: begin
        mem_re = (ci_q != sha1md_pkg::CI_LAST);
        ci_d   = ci_q + 3'd1;
        if (ci_q != 3'd0) begin
          work_d = '{a: work_q.b, b: work_q.c, c: work_q.d, d: work_q.e, e: rd_eff};
        end
      end
      sha1md_pkg::ST_ROUND: begin
        work_d = work_rnd;
        blk_d  = {blk_q[14:0], sched_new};
        rnd_d  = rnd_q + 7'd1;
      end
      sha1md_pkg::ST_ADD: begin
        mem_re = (ci_q != sha1md_pkg::CI_LAST);
        ci_d   = ci_q + 3'd1;
        if (ci_q != 3'd0) begin
          mem_we             = 1'b1;
          cvalid_d[rd_idx_q] = 1'b1;
          work_d = '{a: work_q.b, b: work_q.c, c: work_q.d, d: work_q.e, e: work_q.a};
        end
      end
      sha1md_pkg::ST_PAD: begin
        byte_en = 1'b1;
        byte_v  = mark_q ? 8'h00 : sha1md_pkg::PAD_BYTE;
        mark_d  = 1'b1;
      end
      sha1md_pkg::ST_LEN: begin
        blk_d  = {blk_q[13:0], msg_q, 3'b000};
        last_d = 1'b1;
        pos_d  = 6'd0;
      end
      sha1md_pkg::ST_OUT_RD: begin
        mem_re = 1'b1;
        mem_ra = wi_q;
      end
      sha1md_pkg::ST_OUT_LD: begin
        m_data_d  = rd_eff;
        m_num_d   = wi_q;
        m_valid_d = 1'b1;
        wi_d      = wi_q + 3'd1;
        if (wi_q == sha1md_pkg::WORD_LAST) begin
          wi_d     = 3'd0;
          cvalid_d = '0;
          pos_d    = 6'd0;
          msg_d    = '0;
          fin_d    = 1'b0;
          mark_d   = 1'b0;
          last_d   = 1'b0;
        end
      end
      default: ;
    endcase

    if (byte_en) begin
      blk_d = {blk_q[15][23:0], blk_q[14:0], byte_v};
      pos_d = pos_q + 6'd1;
    end

    if (state_d != state_q) begin
      ci_d  = 3'd0;
      rnd_d = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1md_pkg::ST_IDLE;
      pos_q     <= '0;
      msg_q     <= '0;
      fin_q     <= 1'b0;
      mark_q    <= 1'b0;
      last_q    <= 1'b0;
      ci_q      <= '0;
      rnd_q     <= '0;
      wi_q      <= '0;
      cvalid_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      msg_q     <= msg_d;
      fin_q     <= fin_d;
      mark_q    <= mark_d;
      last_q    <= last_d;
      ci_q      <= ci_d;
      rnd_q     <= rnd_d;
      wi_q      <= wi_d;
      cvalid_q  <= cvalid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    work_q   <= work_d;
    m_data_q <= m_data_d;
    m_num_q  <= m_num_d;
  end

  // chain word RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chain_mem[rd_idx_q] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= chain_mem[mem_ra];
      rd_idx_q <= mem_ra;
    end
  end

  a_last_is_word4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == sha1md_pkg::WORD_LAST)
    else $error("digest_done on wrong word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha1md_pkg::ST_OUT_LD |-> !m_valid_q)
    else $error("output beat overwritten");

  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && pos_q == sha1md_pkg::POS_LAST |=> state_q == sha1md_pkg::ST_LOAD)
    else $error("full block not compressed");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha1md_pkg::ST_ROUND |-> rnd_q <= sha1md_pkg::ROUND_LAST)
    else $error("round counter out of range");

  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha1md_pkg::ST_LEN |-> pos_q == 6'd56 && mark_q)
    else $error("length inserted at wrong position");

endmodule
